FILE: rtl/ffrs_pkg.sv
// shared types and constants for the first-fit region search block
package ffrs_pkg;

   localparam int ADDR_BITS    = 48;
   localparam int SLOT_BITS    = 6;
   localparam int COUNT_BITS   = 6;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [ADDR_BITS-1:0] KERNEL_LIMIT_RESET = ADDR_BITS'(1048575);

   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_LIMIT = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAP_COUNT    = CSR_IDX_BITS'(1);

   typedef enum logic [1:0] {
      CMD_MAP_LOAD    = 2'd0,
      CMD_ALLOC_SET   = 2'd1,
      CMD_ALLOC_CLEAR = 2'd2,
      CMD_SEARCH      = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_RD,
      ST_MAP_EVAL,
      ST_CHECK,
      ST_SWEEP,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic search_start;
      logic map_rd;
      logic map_next;
      logic range_start;
      logic sweep_start;
      logic alloc_rd;
      logic jump;
      logic rsp_load;
      logic rsp_found;
   } ctrl_type;

   typedef struct packed {
      logic map_done;
      logic skip_entry;
      logic range_fail;
      logic sweep_last;
      logic have_block;
      logic rsp_free;
   } status_type;

endpackage

FILE: rtl/ffrs_channels.sv
// request, response and register-write channel interfaces
interface ffrs_req_if;
   logic                               valid;
   logic                               ready;
   ffrs_pkg::cmd_type                  cmd;
   logic [ffrs_pkg::SLOT_BITS-1:0]     slot;
   logic [ffrs_pkg::ADDR_BITS-1:0]     region_base;
   logic [ffrs_pkg::ADDR_BITS-1:0]     region_length;
   logic                               region_usable;
   logic [ffrs_pkg::ADDR_BITS-1:0]     request_size;

   modport source (
      output valid, cmd, slot, region_base, region_length, region_usable, request_size,
      input  ready
   );
   modport sink (
      input  valid, cmd, slot, region_base, region_length, region_usable, request_size,
      output ready
   );
endinterface

interface ffrs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               found;
   logic [ffrs_pkg::ADDR_BITS-1:0]     fit_address;

   modport source (output valid, found, fit_address, input ready);
   modport sink (input valid, found, fit_address, output ready);
endinterface

interface ffrs_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ffrs_pkg::CSR_IDX_BITS-1:0]  index;
   logic [ffrs_pkg::ADDR_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ffrs_ctrl.sv
// search sequencer: walks map entries, overlap checks and table sweeps
module ffrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_search,
   output logic                 req_ready,
   input  ffrs_pkg::status_type status,
   output ffrs_pkg::ctrl_type   ctrl
);

   ffrs_pkg::state_type state_ff;
   ffrs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffrs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ffrs_pkg::ST_IDLE: begin
            // table writes complete on accept, only a search leaves idle
            req_ready = 1'b1;
            if (req_valid && req_search) begin
               ctrl.search_start = 1'b1;
               state_in          = ffrs_pkg::ST_MAP_RD;
            end
         end
         ffrs_pkg::ST_MAP_RD: begin
            if (status.map_done) begin
               if (status.rsp_free) begin
                  ctrl.rsp_load = 1'b1;
                  state_in      = ffrs_pkg::ST_IDLE;
               end
            end else begin
               ctrl.map_rd = 1'b1;
               state_in    = ffrs_pkg::ST_MAP_EVAL;
            end
         end
         ffrs_pkg::ST_MAP_EVAL: begin
            if (status.skip_entry) begin
               ctrl.map_next = 1'b1;
               state_in      = ffrs_pkg::ST_MAP_RD;
            end else begin
               ctrl.range_start = 1'b1;
               state_in         = ffrs_pkg::ST_CHECK;
            end
         end
         ffrs_pkg::ST_CHECK: begin
            if (status.range_fail) begin
               ctrl.map_next = 1'b1;
               state_in      = ffrs_pkg::ST_MAP_RD;
            end else begin
               ctrl.sweep_start = 1'b1;
               state_in         = ffrs_pkg::ST_SWEEP;
            end
         end
         ffrs_pkg::ST_SWEEP: begin
            ctrl.alloc_rd = 1'b1;
            if (status.sweep_last) begin
               state_in = ffrs_pkg::ST_DRAIN;
            end
         end
         ffrs_pkg::ST_DRAIN: begin
            // last table entry is compared in this cycle
            state_in = ffrs_pkg::ST_DECIDE;
         end
         ffrs_pkg::ST_DECIDE: begin
            if (status.have_block) begin
               ctrl.jump = 1'b1;
               state_in  = ffrs_pkg::ST_CHECK;
            end else if (status.rsp_free) begin
               ctrl.rsp_load  = 1'b1;
               ctrl.rsp_found = 1'b1;
               state_in       = ffrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffrs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/ffrs_dpath.sv
// tables, registers, candidate arithmetic and response register
module ffrs_dpath #(
   parameter int MAP_ENTRIES   = 32,
   parameter int ALLOC_ENTRIES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_accept,
   input  ffrs_pkg::cmd_type                    cmd,
   input  logic [ffrs_pkg::SLOT_BITS-1:0]       slot,
   input  logic [ffrs_pkg::ADDR_BITS-1:0]       region_base,
   input  logic [ffrs_pkg::ADDR_BITS-1:0]       region_length,
   input  logic                                 region_usable,
   input  logic [ffrs_pkg::ADDR_BITS-1:0]       request_size,
   input  logic                                 csr_valid,
   input  logic [ffrs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ffrs_pkg::ADDR_BITS-1:0]       csr_data,
   input  ffrs_pkg::ctrl_type                   ctrl,
   output ffrs_pkg::status_type                 status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_found,
   output logic [ffrs_pkg::ADDR_BITS-1:0]       rsp_addr
);

   localparam int AB  = ffrs_pkg::ADDR_BITS;
   localparam int AW1 = AB + 1;
   localparam int AW2 = AB + 2;
   localparam int MAW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int MCW = $clog2(MAP_ENTRIES + 1);
   localparam int AAW = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;

   // register file
   logic [AB-1:0]                      krl_ff;
   logic [ffrs_pkg::COUNT_BITS-1:0]    map_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         krl_ff       <= ffrs_pkg::KERNEL_LIMIT_RESET;
         map_count_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ffrs_pkg::CSR_KERNEL_LIMIT: krl_ff       <= csr_data;
            ffrs_pkg::CSR_MAP_COUNT:    map_count_ff <= csr_data[ffrs_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // request decode, zero length or size counts as one
   logic [AB-1:0]  len_eff;
   logic [AB-1:0]  size_eff;
   logic [AW1-1:0] wr_end;
   logic           map_wr;
   logic           alloc_set;
   logic           alloc_clr;

   assign len_eff   = (region_length == '0) ? AB'(1) : region_length;
   assign size_eff  = (request_size == '0) ? AB'(1) : request_size;
   assign wr_end    = {1'b0, region_base} + {1'b0, len_eff};
   assign map_wr    = req_accept && (cmd == ffrs_pkg::CMD_MAP_LOAD)
                      && (32'(slot) < MAP_ENTRIES);
   assign alloc_set = req_accept && (cmd == ffrs_pkg::CMD_ALLOC_SET)
                      && (32'(slot) < ALLOC_ENTRIES);
   assign alloc_clr = req_accept && (cmd == ffrs_pkg::CMD_ALLOC_CLEAR)
                      && (32'(slot) < ALLOC_ENTRIES);

   // memory map table, end = base + length kept one bit wider
   logic [AB-1:0]  map_base_mem   [MAP_ENTRIES];
   logic [AW1-1:0] map_end_mem    [MAP_ENTRIES];
   logic           map_usable_mem [MAP_ENTRIES];
   logic [AB-1:0]  map_base_q_ff;
   logic [AW1-1:0] map_end_q_ff;
   logic           map_usable_q_ff;
   logic [MCW-1:0] map_idx_ff;
   logic [MCW-1:0] count_eff;

   always_ff @(posedge clock) begin
      if (map_wr) begin
         map_base_mem[MAW'(slot)]   <= region_base;
         map_end_mem[MAW'(slot)]    <= wr_end;
         map_usable_mem[MAW'(slot)] <= region_usable;
      end
      if (ctrl.map_rd) begin
         map_base_q_ff   <= map_base_mem[map_idx_ff[MAW-1:0]];
         map_end_q_ff    <= map_end_mem[map_idx_ff[MAW-1:0]];
         map_usable_q_ff <= map_usable_mem[map_idx_ff[MAW-1:0]];
      end
   end

   assign count_eff = (32'(map_count_ff) >= MAP_ENTRIES) ? MCW'(MAP_ENTRIES)
                                                          : MCW'(map_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         map_idx_ff <= '0;
      end else if (ctrl.search_start) begin
         map_idx_ff <= '0;
      end else if (ctrl.map_next) begin
         map_idx_ff <= map_idx_ff + MCW'(1);
      end
   end

   // allocation table, valid bits in flops
   logic [AB-1:0]            alloc_base_mem [ALLOC_ENTRIES];
   logic [AW1-1:0]           alloc_end_mem  [ALLOC_ENTRIES];
   logic [ALLOC_ENTRIES-1:0] alloc_valid_ff;
   logic [AB-1:0]            ab_q_ff;
   logic [AW1-1:0]           ae_q_ff;
   logic                     av_q_ff;
   logic                     eval_ff;
   logic [AAW-1:0]           sweep_ff;

   always_ff @(posedge clock) begin
      if (alloc_set) begin
         alloc_base_mem[AAW'(slot)] <= region_base;
         alloc_end_mem[AAW'(slot)]  <= wr_end;
      end
      if (ctrl.alloc_rd) begin
         ab_q_ff <= alloc_base_mem[sweep_ff];
         ae_q_ff <= alloc_end_mem[sweep_ff];
         av_q_ff <= alloc_valid_ff[sweep_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_valid_ff <= '0;
         eval_ff        <= 1'b0;
         sweep_ff       <= '0;
      end else begin
         if (alloc_set) begin
            alloc_valid_ff[AAW'(slot)] <= 1'b1;
         end else if (alloc_clr) begin
            alloc_valid_ff[AAW'(slot)] <= 1'b0;
         end
         eval_ff <= ctrl.alloc_rd;
         if (ctrl.sweep_start) begin
            sweep_ff <= '0;
         end else if (ctrl.alloc_rd) begin
            sweep_ff <= sweep_ff + AAW'(1);
         end
      end
   end

   // candidate window [cur, lim - 1] inside range ending at range_end
   logic [AB-1:0]  size_ff;
   logic [AW1-1:0] cur_ff;
   logic [AW1-1:0] range_end_ff;
   logic [AW2-1:0] lim_ff;
   logic [AW2-1:0] cur_lim;
   logic [AW1-1:0] krl_next;
   logic           start_above;
   logic [AW1-1:0] best_end_ff;

   assign start_above = map_base_q_ff > krl_ff;
   assign krl_next    = {1'b0, krl_ff} + AW1'(1);
   assign cur_lim     = {1'b0, cur_ff} + {2'b00, size_ff};

   always_ff @(posedge clock) begin
      if (ctrl.search_start) begin
         size_ff <= size_eff;
      end
      if (ctrl.range_start) begin
         cur_ff       <= start_above ? {1'b0, map_base_q_ff} : krl_next;
         range_end_ff <= map_end_q_ff;
      end else if (ctrl.jump) begin
         cur_ff <= best_end_ff;
      end
      if (ctrl.sweep_start) begin
         lim_ff <= cur_lim;
      end
   end

   // blocking allocation: overlapping entry with highest base, lowest slot on ties
   logic [AB-1:0]  best_base_ff;
   logic           have_ff;
   logic           hit;

   assign hit = eval_ff && av_q_ff && ({2'b00, ab_q_ff} < lim_ff) && (ae_q_ff > cur_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (ctrl.sweep_start) begin
         have_ff <= 1'b0;
      end else if (hit && (!have_ff || (ab_q_ff > best_base_ff))) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hit && (!have_ff || (ab_q_ff > best_base_ff))) begin
         best_base_ff <= ab_q_ff;
         best_end_ff  <= ae_q_ff;
      end
   end

   // response register
   logic          rsp_valid_ff;
   logic          rsp_found_ff;
   logic [AB-1:0] rsp_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_found_ff <= ctrl.rsp_found;
         rsp_addr_ff  <= ctrl.rsp_found ? cur_ff[AB-1:0] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_addr  = rsp_addr_ff;

   always_comb begin
      status.map_done   = (map_idx_ff == count_eff);
      status.skip_entry = !map_usable_q_ff
                          || (!start_above && (map_end_q_ff <= {1'b0, krl_ff}));
      status.range_fail = (cur_lim > {1'b0, range_end_ff}) || cur_ff[AB];
      status.sweep_last = (sweep_ff == AAW'(ALLOC_ENTRIES - 1));
      status.have_block = have_ff;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

FILE: rtl/first_fit_region_search.sv
// first-fit region search top level: sequencer, datapath and channel hookup
// Map-load, allocation-set and allocation-clear requests complete on acceptance and return
// no response. A search walks map entries in order, reading each entry (ST_MAP_RD) and then
// qualifying it (ST_MAP_EVAL); for every candidate address it runs a check (ST_CHECK), then a
// sweep of the allocation table, one entry per clock through its single read port, to find
// the blocking allocation (ST_SWEEP, ST_DRAIN, ST_DECIDE). While a search runs no request is
// taken; a finished response waits in an output register, and the next request is taken
// meanwhile. There is no clearing pass after reset.
module first_fit_region_search #(
   parameter int MAP_ENTRIES   = 32,
   parameter int ALLOC_ENTRIES = 64
) (
   input logic        clock,
   input logic        reset,
   ffrs_req_if.sink   req_bus,
   ffrs_rsp_if.source rsp_bus,
   ffrs_csr_if.sink   csr_bus
);

   ffrs_pkg::ctrl_type   ctrl;
   ffrs_pkg::status_type status;
   logic                 req_ready;
   logic                 req_accept;
   logic                 req_search;

   assign req_bus.ready = req_ready;
   assign req_accept    = req_bus.valid && req_ready;
   assign req_search    = (req_bus.cmd == ffrs_pkg::CMD_SEARCH);
   assign csr_bus.ready = 1'b1;

   ffrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_search (req_search),
      .req_ready  (req_ready),
      .status     (status),
      .ctrl       (ctrl)
   );

   ffrs_dpath #(
      .MAP_ENTRIES   (MAP_ENTRIES),
      .ALLOC_ENTRIES (ALLOC_ENTRIES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .cmd           (req_bus.cmd),
      .slot          (req_bus.slot),
      .region_base   (req_bus.region_base),
      .region_length (req_bus.region_length),
      .region_usable (req_bus.region_usable),
      .request_size  (req_bus.request_size),
      .csr_valid     (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .ctrl          (ctrl),
      .status        (status),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_found     (rsp_bus.found),
      .rsp_addr      (rsp_bus.fit_address)
   );

`ifndef SYNTHESIS
   a_load_needs_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> status.rsp_free)
      else $error("response loaded while previous response still pending");

   a_load_shows_response: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |=> rsp_bus.valid)
      else $error("response load did not raise valid");

   a_miss_reports_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.found) |-> (rsp_bus.fit_address == '0))
      else $error("failed search with nonzero address");

   a_single_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.map_next, ctrl.range_start, ctrl.sweep_start, ctrl.jump, ctrl.rsp_load}))
      else $error("conflicting sequencer commands");
`endif

endmodule
